/* rtl/mbc1_pkg.sv */
package mbc1_pkg;

	// Defaults for the top-level parameters
	localparam int unsigned RAM_BYTES_DEF     = 32768;
	localparam int unsigned ROM_ADDR_BITS_DEF = 21;

	// Fixed field widths
	localparam int unsigned ADDR_W     = 16;
	localparam int unsigned DATA_W     = 8;
	localparam int unsigned ROM_W      = 21;
	localparam int unsigned RAM_OFF_W  = 15;
	localparam int unsigned LOW_BANK_W = 5;
	localparam int unsigned HIGH_BANK_W = 2;

	// Request operations
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Result regions
	localparam logic [1:0] REGION_ROM  = 2'd0;
	localparam logic [1:0] REGION_RAM  = 2'd1;
	localparam logic [1:0] REGION_NONE = 2'd2;

	// Control register windows, picked by address bits 14:13 below 0x8000
	localparam logic [1:0] CTL_RAM_EN    = 2'd0;
	localparam logic [1:0] CTL_LOW_BANK  = 2'd1;
	localparam logic [1:0] CTL_HIGH_BANK = 2'd2;
	localparam logic [1:0] CTL_MODE      = 2'd3;

	localparam logic [3:0] RAM_EN_KEY    = 4'hA;
	localparam logic [2:0] RAM_WINDOW_HI = 3'b101;

	typedef struct packed {
		logic              operation;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] write_data;
	} req_t;

	typedef struct packed {
		logic [1:0]        region;
		logic [ROM_W-1:0]  rom_address;
		logic [DATA_W-1:0] read_data;
		logic              ram_enabled;
	} rsp_t;

	// One access to the external RAM store
	typedef struct packed {
		logic                 en;
		logic                 wr;
		logic [RAM_OFF_W-1:0] addr;
		logic [DATA_W-1:0]    wdata;
	} ram_acc_t;

endpackage

/* rtl/mbc1_bank_mapper_top.sv */
// Bank controller for a cartridge bus. A request is taken on any cycle with
// start high (busy never rises), and its result appears with result_valid
// in the next cycle, one request per cycle sustained; its read data comes
// from the registered read of the single-port RAM store. The receiver cannot
// stall: sample the result in the cycle result_valid is high. Control writes
// below 0x8000 set the enable flag, banks and mode; ROM reads return the
// physical address; 0xA000-0xBFFF reaches the RAM store. A RAM byte must be
// written before it is read; the store has no reset and no clearing pass.
module mbc1_bank_mapper_top #(
	parameter int unsigned RAM_BYTES     = mbc1_pkg::RAM_BYTES_DEF,
	parameter int unsigned ROM_ADDR_BITS = mbc1_pkg::ROM_ADDR_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  mbc1_pkg::req_t  request,
	output logic            result_valid,
	output mbc1_pkg::rsp_t  result
);
	import mbc1_pkg::*;

	ram_acc_t          acc;
	logic              take;
	logic [1:0]        region_s1;
	logic [ROM_W-1:0]  rom_s1;
	logic              flag_s1;
	logic              ram_rd_s1;
	logic [DATA_W-1:0] rdata;

	assign busy = 1'b0;
	assign take = start & ~busy;

	mbc1_map #(
		.RAM_BYTES     (RAM_BYTES),
		.ROM_ADDR_BITS (ROM_ADDR_BITS)
	) u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.req       (request),
		.acc       (acc),
		.valid_s1  (result_valid),
		.region_s1 (region_s1),
		.rom_s1    (rom_s1),
		.flag_s1   (flag_s1),
		.ram_rd_s1 (ram_rd_s1)
	);

	mbc1_ram #(
		.RAM_BYTES (RAM_BYTES)
	) u_ram (
		.clk   (clk),
		.acc   (acc),
		.rdata (rdata)
	);

	always_comb begin
		result.region      = region_s1;
		result.rom_address = rom_s1;
		result.read_data   = ram_rd_s1 ? rdata : '0;
		result.ram_enabled = flag_s1;
	end

endmodule

/* rtl/mbc1_ram.sv */
module mbc1_ram #(
	parameter int unsigned RAM_BYTES = 32768
) (
	input  logic                           clk,
	input  mbc1_pkg::ram_acc_t             acc,
	output logic [mbc1_pkg::DATA_W-1:0]    rdata
);
	import mbc1_pkg::*;

	localparam int unsigned AW = $clog2(RAM_BYTES);

	logic [DATA_W-1:0] mem [RAM_BYTES];
	logic [AW-1:0]     idx;

	assign idx = acc.addr[AW-1:0];

	always_ff @(posedge clk) begin
		if (acc.en) begin
			if (acc.wr) begin
				mem[idx] <= acc.wdata;
			end else begin
				rdata <= mem[idx];
			end
		end
	end

endmodule

/* rtl/mbc1_map.sv */
module mbc1_map #(
	parameter int unsigned RAM_BYTES     = 32768,
	parameter int unsigned ROM_ADDR_BITS = 21
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               take,
	input  mbc1_pkg::req_t                     req,
	output mbc1_pkg::ram_acc_t                 acc,
	output logic                               valid_s1,
	output logic [1:0]                         region_s1,
	output logic [mbc1_pkg::ROM_W-1:0]         rom_s1,
	output logic                               flag_s1,
	output logic                               ram_rd_s1
);
	import mbc1_pkg::*;

	localparam logic [RAM_OFF_W:0] RamSize = (RAM_OFF_W+1)'(RAM_BYTES);

	logic [LOW_BANK_W-1:0]  low_bank_q;
	logic [HIGH_BANK_W-1:0] high_bank_q;
	logic                   mode_q;
	logic                   flag_q;

	logic                   is_low;
	logic                   is_ram;
	logic                   ctl_wr;
	logic                   flag_d;
	logic [LOW_BANK_W-1:0]  bank_eff;
	logic [ROM_W-1:0]       rom_full;
	logic [ROM_W-1:0]       rom_cut;
	logic [1:0]             region_d;
	logic [RAM_OFF_W:0]     off;

	assign is_low = ~req.address[ADDR_W-1];
	assign is_ram = req.address[ADDR_W-1 -: 3] == RAM_WINDOW_HI;
	assign ctl_wr = take & is_low & (req.operation == OP_WRITE);

	// Next enable flag, reported with this request's result
	always_comb begin
		flag_d = flag_q;
		if (is_low && req.operation == OP_WRITE && req.address[14:13] == CTL_RAM_EN) begin
			flag_d = req.write_data[3:0] == RAM_EN_KEY;
		end
	end

	// ROM mapping; a low bank of zero acts as one in the switchable window
	always_comb begin
		bank_eff = (low_bank_q == '0) ? LOW_BANK_W'(1) : low_bank_q;
		if (!req.address[14]) begin
			rom_full = {(mode_q ? high_bank_q : 2'b00), 5'b0, req.address[13:0]};
		end else begin
			rom_full = {high_bank_q, bank_eff, req.address[13:0]};
		end
		rom_cut = ROM_W'(rom_full[ROM_ADDR_BITS-1:0]);
	end

	// RAM offset, folded into the store size
	always_comb begin
		off = {1'b0, (mode_q ? high_bank_q : 2'b00), req.address[12:0]};
		for (int i = 0; i < 3; i++) begin
			if (off >= RamSize) begin
				off = off - RamSize;
			end
		end
	end

	always_comb begin
		priority if (is_low && req.operation == OP_READ) begin
			region_d = REGION_ROM;
		end else if (is_ram) begin
			region_d = REGION_RAM;
		end else begin
			region_d = REGION_NONE;
		end
	end

	always_comb begin
		acc.en    = take & is_ram;
		acc.wr    = req.operation == OP_WRITE;
		acc.addr  = off[RAM_OFF_W-1:0];
		acc.wdata = req.write_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_bank_q  <= '0;
			high_bank_q <= '0;
			mode_q      <= 1'b0;
			flag_q      <= 1'b0;
		end else if (ctl_wr) begin
			unique case (req.address[14:13])
				CTL_RAM_EN:    flag_q      <= flag_d;
				CTL_LOW_BANK:  low_bank_q  <= req.write_data[LOW_BANK_W-1:0];
				CTL_HIGH_BANK: high_bank_q <= req.write_data[HIGH_BANK_W-1:0];
				CTL_MODE:      mode_q      <= req.write_data[0];
				default:       mode_q      <= mode_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			region_s1 <= region_d;
			rom_s1    <= (region_d == REGION_ROM) ? rom_cut : '0;
			flag_s1   <= flag_d;
			ram_rd_s1 <= is_ram & (req.operation == OP_READ);
		end
	end

endmodule

/* tb/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mbc1_pkg::*;

	class mapper_checker;
		logic [LOW_BANK_W-1:0]  low_bank;
		logic [HIGH_BANK_W-1:0] high_bank;
		logic                   bank_mode;
		logic                   ram_en;
		logic [DATA_W-1:0]      ram_image [RAM_BYTES_DEF];
		rsp_t                   pending_results [$];
		int unsigned            failures;
		int unsigned            n_control, n_rom, n_ram_rd, n_ram_wr, n_unmapped, n_checked;

		function new();
			low_bank   = '0;
			high_bank  = '0;
			bank_mode  = 1'b0;
			ram_en     = 1'b0;
			failures   = 0;
			n_control  = 0;
			n_rom      = 0;
			n_ram_rd   = 0;
			n_ram_wr   = 0;
			n_unmapped = 0;
			n_checked  = 0;
		endfunction

		// Bank bits that sit above the 8 KiB RAM window
		function logic [HIGH_BANK_W-1:0] ram_bank();
			return bank_mode ? high_bank : '0;
		endfunction

		function void note_request(req_t r);
			rsp_t                 e;
			logic [RAM_OFF_W-1:0] off;
			e = '0;
			e.region = REGION_NONE;
			if (!r.address[15]) begin
				if (r.operation == OP_WRITE) begin
					n_control++;
					case (r.address[14:13])
						CTL_RAM_EN:    ram_en = (r.write_data[3:0] == RAM_EN_KEY);
						CTL_LOW_BANK:  low_bank = r.write_data[LOW_BANK_W-1:0];
						CTL_HIGH_BANK: high_bank = r.write_data[HIGH_BANK_W-1:0];
						CTL_MODE:      bank_mode = r.write_data[0];
					endcase
				end else begin
					n_rom++;
					e.region = REGION_ROM;
					if (!r.address[14]) begin
						e.rom_address = {ram_bank(), 5'd0, r.address[13:0]};
					end else begin
						// a low bank of zero maps as bank one
						e.rom_address = {high_bank, (low_bank == '0) ? 5'd1 : low_bank,
							r.address[13:0]};
					end
				end
			end else if (r.address[15:13] == RAM_WINDOW_HI) begin
				e.region = REGION_RAM;
				off = {ram_bank(), r.address[12:0]};
				if (r.operation == OP_WRITE) begin
					n_ram_wr++;
					ram_image[off] = r.write_data;
				end else begin
					n_ram_rd++;
					e.read_data = ram_image[off];
				end
			end else begin
				n_unmapped++;
			end
			e.ram_enabled = ram_en;
			pending_results.push_back(e);
		endfunction

		function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
			if (got_v !== exp_v) begin
				failures++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v,
					got_v);
			end
		endfunction

		function void check_result(rsp_t got);
			rsp_t e;
			if (pending_results.size() == 0) begin
				failures++;
				$display("%0t: unexpected result, expected none, actual %0h", $time, got);
				return;
			end
			e = pending_results.pop_front();
			n_checked++;
			compare_field("region", 32'(e.region), 32'(got.region));
			compare_field("rom_address", 32'(e.rom_address), 32'(got.rom_address));
			compare_field("read_data", 32'(e.read_data), 32'(got.read_data));
			compare_field("ram_enabled", 32'(e.ram_enabled), 32'(got.ram_enabled));
		endfunction
	endclass

	logic  clk = 1'b0;
	logic  arst_n;
	logic  start;
	logic  busy;
	req_t  request;
	logic  result_valid;
	rsp_t  result;

	mapper_checker        sb;
	logic [RAM_OFF_W-1:0] written_offs [$];

	mbc1_bank_mapper_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_valid (result_valid),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (sb != null && result_valid)
			sb.check_result(result);
	end

	task automatic issue(input req_t r);
		start   <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
		// remember which RAM bytes hold data so reads stay on written ones
		if (r.operation == OP_WRITE && r.address[15:13] == RAM_WINDOW_HI)
			written_offs.push_back({sb.ram_bank(), r.address[12:0]});
		sb.note_request(r);
	endtask

	task automatic idle(input int unsigned n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic issue_op(input logic op, input logic [ADDR_W-1:0] a,
			input logic [DATA_W-1:0] d);
		req_t r;
		r.operation  = op;
		r.address    = a;
		r.write_data = d;
		issue(r);
	endtask

	function automatic req_t next_request();
		req_t                 r;
		int unsigned          kind;
		logic [1:0]           sel;
		logic [RAM_OFF_W-1:0] off;
		bit                   found;
		r.operation  = OP_READ;
		r.address    = 16'($urandom);
		r.write_data = 8'($urandom);
		kind = $urandom_range(0, 99);
		if (kind < 25) begin
			sel = 2'($urandom_range(0, 3));
			r.operation = OP_WRITE;
			r.address   = {1'b0, sel, 13'($urandom)};
			if (sel == CTL_RAM_EN && $urandom_range(0, 1) == 0)
				r.write_data[3:0] = RAM_EN_KEY;
			if (sel == CTL_LOW_BANK && $urandom_range(0, 3) == 0)
				r.write_data[4:0] = '0;
		end else if (kind < 55) begin
			r.address[15] = 1'b0;
		end else if (kind < 90) begin
			r.address[15:13] = RAM_WINDOW_HI;
			found = 1'b0;
			if (kind >= 75) begin
				for (int i = 0; i < 16 && !found && written_offs.size() != 0; i++) begin
					off = written_offs[$urandom_range(0, written_offs.size() - 1)];
					if (off[14:13] == sb.ram_bank()) begin
						r.address[12:0] = off[12:0];
						found = 1'b1;
					end
				end
			end
			// fall back to a write when nothing readable sits in this bank
			r.operation = found ? OP_READ : OP_WRITE;
		end else begin
			r.operation = logic'($urandom_range(0, 1));
			if ($urandom_range(0, 1) == 0)
				r.address[15:13] = 3'b100;
			else
				r.address[15:14] = 2'b11;
		end
		return r;
	endfunction

	initial begin
		int unsigned issued;
		int unsigned guard;
		sb = new();
		arst_n  <= 1'b0;
		start   <= 1'b0;
		request <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset state, window edges, low bank zero
		issue_op(OP_READ, 16'h0000, 8'h00);
		issue_op(OP_READ, 16'h3FFF, 8'hFF);
		issue_op(OP_READ, 16'h4000, 8'h00);
		issue_op(OP_WRITE, 16'h0000, 8'h0A);
		issue_op(OP_WRITE, 16'h2000, 8'hFF);
		issue_op(OP_READ, 16'h7FFF, 8'h00);
		issue_op(OP_WRITE, 16'h3FFF, 8'h20);
		issue_op(OP_READ, 16'h4000, 8'h00);
		issue_op(OP_WRITE, 16'h4000, 8'hFF);
		issue_op(OP_READ, 16'h4000, 8'h00);
		issue_op(OP_READ, 16'h3FFF, 8'h00);
		issue_op(OP_WRITE, 16'h7FFF, 8'hFF);
		issue_op(OP_READ, 16'h0000, 8'h00);
		issue_op(OP_WRITE, 16'hA000, 8'h00);
		issue_op(OP_WRITE, 16'hBFFF, 8'hFF);
		issue_op(OP_READ, 16'hBFFF, 8'h00);
		issue_op(OP_READ, 16'hA000, 8'hFF);
		issue_op(OP_WRITE, 16'h6000, 8'hFE);
		issue_op(OP_WRITE, 16'hA000, 8'h5A);
		issue_op(OP_READ, 16'hA000, 8'h00);
		issue_op(OP_READ, 16'h8000, 8'h00);
		issue_op(OP_WRITE, 16'h9FFF, 8'h55);
		issue_op(OP_READ, 16'hC000, 8'h00);
		issue_op(OP_WRITE, 16'hFFFF, 8'hAA);
		issue_op(OP_WRITE, 16'h1FFF, 8'h1B);
		idle(3);

		issued = 0;
		while (issued < 800) begin
			repeat ($urandom_range(1, 24)) begin
				issue(next_request());
				issued++;
			end
			if ($urandom_range(0, 3) != 0)
				idle($urandom_range(1, 6));
		end
		start <= 1'b0;

		guard = 0;
		while (sb.pending_results.size() != 0 && guard < 50) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
		if (sb.pending_results.size() != 0) begin
			sb.failures++;
			$display("%0t: %0d results never arrived, expected none outstanding", $time,
				sb.pending_results.size());
		end

		$display("Checked %0d results: %0d ROM reads, %0d RAM writes, %0d RAM reads,",
			sb.n_checked, sb.n_rom, sb.n_ram_wr, sb.n_ram_rd);
		$display("%0d control writes and %0d unmapped accesses, %0d mismatches.",
			sb.n_control, sb.n_unmapped, sb.failures);
		if (sb.failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timeout: run did not finish");
		$display("Test completed with failures");
		$finish;
	end

endmodule
